// ----- sv/ctb_pkg.sv -----
// Shared types and constants for the clipped tilemap blit.
package ctb_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH   = 3'd0,
        CFG_SRC_HEIGHT  = 3'd1,
        CFG_X_ORIGIN    = 3'd2,
        CFG_Y_ORIGIN    = 3'd3,
        CFG_TILE_OFFSET = 3'd4
    } cfg_reg_t;

    // Field widths
    localparam int SIZE_W   = 9;
    localparam int COORD_W  = 16;
    localparam int ENTRY_W  = 16;
    localparam int COUNT_W  = 8;
    localparam int INDEX_W  = 10;
    localparam int TDATA_W  = 32;
    localparam int POS_W    = 18;

    // Active configuration, sizes already clamped to 1..256
    typedef struct packed {
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
        logic [COORD_W-1:0] x_origin;
        logic [COORD_W-1:0] y_origin;
        logic [ENTRY_W-1:0] tile_offset;
    } cfg_t;

    // Position of one entry within the stored image
    typedef struct packed {
        logic [COUNT_W-1:0] column;
        logic [COUNT_W-1:0] row;
    } pos_t;

    // One map write
    typedef struct packed {
        logic [ENTRY_W-1:0] map_value;
        logic [INDEX_W-1:0] map_index;
    } result_t;

endpackage

// ----- sv/clipped_tilemap_blit.sv -----
// Clipped tilemap blit: top level with input stage, placement and output stage.
//
// Copies a tile image, sent one entry per transaction in stored order (rows
// bottom first), into a MAP_SIDE by MAP_SIDE background map. Each entry that
// lands on the map gives one result transaction with its map index
// (row * MAP_SIDE + column, 10 bits) and the entry plus tile_offset; entries
// off the map give nothing but still advance the column and row counters.
// s_tuser[0] marks the first entry of an image and restarts the counters.
// The block takes one entry per cycle while the output stage has room; a
// result passes the input register and then the output register around
// the placement logic. A two-deep output stage keeps s_tready independent of
// m_tready. Configuration is written through cfg_valid/cfg_index/cfg_data
// (0 src_width, 1 src_height, 2 x_origin, 3 y_origin, 4 tile_offset); the
// user must do so while no entry is in flight, as nothing enforces it.
module clipped_tilemap_blit #(
    parameter int MAP_SIDE = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ctb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ctb_pkg::COORD_W-1:0]    cfg_data,
    // Input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ctb_pkg::ENTRY_W-1:0]    s_tdata,   // [15:0] tile_entry
    input  logic [0:0]                     s_tuser,   // [0] start_image
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ctb_pkg::TDATA_W-1:0]    m_tdata    // [9:0] map_index, [25:10] map_value
);

    ctb_pkg::cfg_t    cfg;
    ctb_pkg::pos_t    pos;
    ctb_pkg::result_t place_result;
    ctb_pkg::result_t out_result;
    logic             place_hit;
    logic             skid_in_ready;
    logic             s_fire;
    logic             s1_advance;

    logic                        s1_valid_reg, s1_valid_next;
    logic [ctb_pkg::ENTRY_W-1:0] s1_entry_reg;
    ctb_pkg::pos_t               s1_pos_reg;

    assign cfg_ready = 1'b1;

    ctb_cfg_regs u_cfg_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign s_fire = s_tvalid && s_tready;

    ctb_pos_counter u_pos_counter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (s_fire),
        .start   (s_tuser[0]),
        .width   (cfg.width),
        .height  (cfg.height),
        .pos     (pos)
    );

    // Input stage: dropped entries leave even when the output stage is full
    assign s1_advance = s1_valid_reg && (skid_in_ready || !place_hit);
    assign s_tready   = !s1_valid_reg || s1_advance;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_fire) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
        if (s_fire) begin
            s1_entry_reg <= s_tdata;
            s1_pos_reg   <= pos;
        end
    end

    ctb_place #(
        .MAP_SIDE (MAP_SIDE)
    ) u_place (
        .cfg        (cfg),
        .pos        (s1_pos_reg),
        .tile_entry (s1_entry_reg),
        .hit        (place_hit),
        .result     (place_result)
    );

    ctb_out_skid u_out_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid_reg && place_hit),
        .in_ready  (skid_in_ready),
        .in_data   (place_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {{(ctb_pkg::TDATA_W - ctb_pkg::ENTRY_W - ctb_pkg::INDEX_W){1'b0}},
                      out_result.map_value, out_result.map_index};

    // A start mark places the entry at the image origin
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tuser[0]) |=> (s1_pos_reg.column == '0 && s1_pos_reg.row == '0))
        else $error("start mark did not clear the position");

    // A hit handed to the output stage shows up as a pending result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && place_hit && skid_in_ready) |=> m_tvalid)
        else $error("placed entry lost before the output");

    // Reset leaves no result pending
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

// ----- sv/ctb_cfg_regs.sv -----
// Configuration register file with size clamping.
module ctb_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           wr_en,
    input  logic [ctb_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [ctb_pkg::COORD_W-1:0]    wr_data,
    output ctb_pkg::cfg_t                  cfg
);

    logic [ctb_pkg::SIZE_W-1:0]  width_reg;
    logic [ctb_pkg::SIZE_W-1:0]  height_reg;
    logic [ctb_pkg::COORD_W-1:0] x_origin_reg;
    logic [ctb_pkg::COORD_W-1:0] y_origin_reg;
    logic [ctb_pkg::ENTRY_W-1:0] tile_offset_reg;

    // Store register writes; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg       <= ctb_pkg::SIZE_W'(1);
            height_reg      <= ctb_pkg::SIZE_W'(1);
            x_origin_reg    <= '0;
            y_origin_reg    <= '0;
            tile_offset_reg <= '0;
        end else if (wr_en) begin
            unique case (ctb_pkg::cfg_reg_t'(wr_index))
                ctb_pkg::CFG_SRC_WIDTH:   width_reg       <= wr_data[ctb_pkg::SIZE_W-1:0];
                ctb_pkg::CFG_SRC_HEIGHT:  height_reg      <= wr_data[ctb_pkg::SIZE_W-1:0];
                ctb_pkg::CFG_X_ORIGIN:    x_origin_reg    <= wr_data;
                ctb_pkg::CFG_Y_ORIGIN:    y_origin_reg    <= wr_data;
                ctb_pkg::CFG_TILE_OFFSET: tile_offset_reg <= wr_data;
                default: ;
            endcase
        end
    end

    // Clamp a size to 1..256: zero acts as one, anything above 256 as 256
    function automatic logic [ctb_pkg::SIZE_W-1:0] clamp_size(
        input logic [ctb_pkg::SIZE_W-1:0] v
    );
        logic [ctb_pkg::SIZE_W-1:0] r;
        if (v == '0) begin
            r = ctb_pkg::SIZE_W'(1);
        end else if (v[ctb_pkg::SIZE_W-1] && (v[ctb_pkg::SIZE_W-2:0] != '0)) begin
            r = ctb_pkg::SIZE_W'(256);
        end else begin
            r = v;
        end
        return r;
    endfunction

    always_comb begin
        cfg.width       = clamp_size(width_reg);
        cfg.height      = clamp_size(height_reg);
        cfg.x_origin    = x_origin_reg;
        cfg.y_origin    = y_origin_reg;
        cfg.tile_offset = tile_offset_reg;
    end

endmodule

// ----- sv/ctb_pos_counter.sv -----
// Column and row counters that track each entry's place in the stored image.
module ctb_pos_counter (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  logic                        start,
    input  logic [ctb_pkg::SIZE_W-1:0]  width,
    input  logic [ctb_pkg::SIZE_W-1:0]  height,
    output ctb_pkg::pos_t               pos
);

    logic [ctb_pkg::COUNT_W-1:0] column_reg, column_next;
    logic [ctb_pkg::COUNT_W-1:0] row_reg, row_next;
    logic [ctb_pkg::COUNT_W-1:0] col_inc, row_inc;

    // Position of the current entry: a start mark clears it first
    always_comb begin
        pos.column = start ? '0 : column_reg;
        pos.row    = start ? '0 : row_reg;
    end

    // Step to the next entry, wrapping at the row end and the image end
    always_comb begin
        col_inc     = pos.column + ctb_pkg::COUNT_W'(1);
        row_inc     = pos.row + ctb_pkg::COUNT_W'(1);
        column_next = col_inc;
        row_next    = pos.row;
        if ((col_inc == '0) || ({1'b0, col_inc} >= width)) begin
            column_next = '0;
            row_next    = row_inc;
            if ((row_inc == '0) || ({1'b0, row_inc} >= height)) begin
                row_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            row_reg    <= '0;
        end else if (advance) begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

    // A start mark restarts the column at the first entry of the image
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && start) |-> (column_next <= ctb_pkg::COUNT_W'(1)))
        else $error("column did not restart after start mark");

endmodule

// ----- sv/ctb_place.sv -----
// Map placement: clip the entry against the map and form index and value.
module ctb_place #(
    parameter int MAP_SIDE = 32
) (
    input  ctb_pkg::cfg_t                 cfg,
    input  ctb_pkg::pos_t                 pos,
    input  logic [ctb_pkg::ENTRY_W-1:0]   tile_entry,
    output logic                          hit,
    output ctb_pkg::result_t              result
);

    localparam logic [ctb_pkg::POS_W-1:0] SIDE = ctb_pkg::POS_W'(MAP_SIDE);

    logic [ctb_pkg::POS_W-1:0] map_col;
    logic [ctb_pkg::POS_W-1:0] map_row;
    logic [ctb_pkg::POS_W-1:0] index_full;

    // Map coordinates: rows are stored bottom first
    always_comb begin
        map_col = {{2{cfg.x_origin[ctb_pkg::COORD_W-1]}}, cfg.x_origin}
                + {10'b0, pos.column};
        map_row = {{2{cfg.y_origin[ctb_pkg::COORD_W-1]}}, cfg.y_origin}
                + {9'b0, cfg.height}
                - ctb_pkg::POS_W'(1)
                - {10'b0, pos.row};
    end

    // Drop anything outside the map
    always_comb begin
        hit = !map_col[ctb_pkg::POS_W-1] && (map_col < SIDE)
           && !map_row[ctb_pkg::POS_W-1] && (map_row < SIDE);
        index_full       = map_row * SIDE + map_col;
        result.map_index = index_full[ctb_pkg::INDEX_W-1:0];
        result.map_value = tile_entry + cfg.tile_offset;
    end

endmodule

// ----- sv/ctb_out_skid.sv -----
// Output register with a skid entry, so in_ready comes from a register and not from m_tready.
module ctb_out_skid (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  ctb_pkg::result_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ctb_pkg::result_t   out_data
);

    logic             out_valid_reg, out_valid_next;
    ctb_pkg::result_t out_data_reg, out_data_next;
    logic             skid_valid_reg, skid_valid_next;
    ctb_pkg::result_t skid_data_reg, skid_data_next;
    logic             in_fire, out_take;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_take  = out_valid_reg && out_ready;

    // Move the skid entry forward, load or park the incoming result, or clear the output once taken
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (out_take) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_fire) begin
            if (!out_valid_reg || out_take) begin
                out_valid_next = 1'b1;
                out_data_next  = in_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = in_data;
            end
        end else if (out_take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // The skid entry is only used behind a full output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    // A parked transaction moves forward once the output is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && out_take) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry not forwarded");

endmodule
